// ===== design/lzd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types, constants and helpers for the LZ77 byte decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzd_pkg;

   localparam int unsigned SIZE_W = 24;
   localparam int unsigned WIN_W  = 12;
   localparam int unsigned LEN_W  = 5;

   localparam logic [SIZE_W-1:0] SIZE_MAX = 24'hFFFFFF;
   localparam logic [LEN_W-1:0]  LEN_BIAS = 5'd3;
   localparam logic [3:0]        FLAG_CNT = 4'd8;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_FLAG,
      PH_LIT,
      PH_TOKLO,
      PH_TOKHI,
      PH_DONE
   } phase_type;

   // One emit command: a literal or a back-reference copy
   typedef struct packed {
      logic              restart;   // window pointer back to zero first
      logic              is_lit;
      logic [7:0]        lit_byte;
      logic [WIN_W-1:0]  disp;
      logic [LEN_W-1:0]  len;
      logic [SIZE_W-1:0] base;      // output count before the first byte
      logic [SIZE_W-1:0] target;
   } cmd_type;

   function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] cnt,
                                                 input logic [LEN_W-1:0] n);
      logic [SIZE_W:0] sum;
      sum = {1'b0, cnt} + {{(SIZE_W+1-LEN_W){1'b0}}, n};
      return sum[SIZE_W] ? SIZE_MAX : sum[SIZE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/lzd_front.sv =====
// ----------------------------------------------------------------------------
// lzd_front
// Parses the compressed stream: header, flag bytes, literals and tokens.
// Tracks the output count and pushes one emit command per emitting request.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic             req_start_req,
   input  wire logic             q_full,
   output logic                  q_push,
   output lzd_pkg::cmd_type      q_cmd
);

   lzd_pkg::phase_type            phase_ff, phase_in, e_phase;
   logic [1:0]                    hdr_ff, hdr_in, e_hdr;
   logic [lzd_pkg::SIZE_W-1:0]    tgt_ff, tgt_in, e_tgt;
   logic [lzd_pkg::SIZE_W-1:0]    cnt_ff, cnt_in, e_cnt;
   logic [7:0]                    flags_ff, flags_in, e_flags;
   logic [3:0]                    idx_ff, idx_in, e_idx;
   logic [7:0]                    tok_ff, tok_in, e_tok;
   logic                          pend_ff, pend_in;
   logic                          accept;

   function automatic lzd_pkg::phase_type choose_next(
      input logic [lzd_pkg::SIZE_W-1:0] cnt,
      input logic [lzd_pkg::SIZE_W-1:0] tgt,
      input logic [3:0]                 idx,
      input logic [7:0]                 flags);
      lzd_pkg::phase_type ph;
      if (cnt >= tgt) begin
         ph = lzd_pkg::PH_DONE;
      end else if (idx >= lzd_pkg::FLAG_CNT) begin
         ph = lzd_pkg::PH_FLAG;
      end else if (flags[7]) begin
         ph = lzd_pkg::PH_TOKLO;
      end else begin
         ph = lzd_pkg::PH_LIT;
      end
      return ph;
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // state as seen by this request, after an optional restart
   always_comb begin
      if (req_start_req) begin
         e_phase = lzd_pkg::PH_HEADER;
         e_hdr   = 2'd0;
         e_tgt   = '0;
         e_cnt   = '0;
         e_flags = '0;
         e_idx   = '0;
         e_tok   = '0;
      end else begin
         e_phase = phase_ff;
         e_hdr   = hdr_ff;
         e_tgt   = tgt_ff;
         e_cnt   = cnt_ff;
         e_flags = flags_ff;
         e_idx   = idx_ff;
         e_tok   = tok_ff;
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      tgt_in   = tgt_ff;
      cnt_in   = cnt_ff;
      flags_in = flags_ff;
      idx_in   = idx_ff;
      tok_in   = tok_ff;
      pend_in  = pend_ff;
      if (accept) begin
         phase_in = e_phase;
         hdr_in   = e_hdr;
         tgt_in   = e_tgt;
         cnt_in   = e_cnt;
         flags_in = e_flags;
         idx_in   = e_idx;
         tok_in   = e_tok;
         pend_in  = pend_ff || req_start_req;
         case (e_phase)
            lzd_pkg::PH_HEADER: begin
               case (e_hdr)
                  2'd1:    tgt_in[7:0]   = req_in_byte;
                  2'd2:    tgt_in[15:8]  = req_in_byte;
                  2'd3:    tgt_in[23:16] = req_in_byte;
                  default: ;
               endcase
               if (e_hdr == 2'd3) begin
                  hdr_in   = 2'd0;
                  idx_in   = lzd_pkg::FLAG_CNT;
                  phase_in = choose_next(e_cnt, tgt_in, lzd_pkg::FLAG_CNT, e_flags);
               end else begin
                  hdr_in = e_hdr + 2'd1;
               end
            end
            lzd_pkg::PH_FLAG: begin
               flags_in = req_in_byte;
               idx_in   = 4'd0;
               phase_in = choose_next(e_cnt, e_tgt, 4'd0, req_in_byte);
            end
            lzd_pkg::PH_LIT: begin
               cnt_in   = lzd_pkg::sat_add(e_cnt, lzd_pkg::LEN_W'(1));
               flags_in = {e_flags[6:0], 1'b0};
               idx_in   = e_idx + 4'd1;
               phase_in = choose_next(cnt_in, e_tgt, idx_in, flags_in);
               pend_in  = 1'b0;
            end
            lzd_pkg::PH_TOKLO: begin
               tok_in   = req_in_byte;
               phase_in = lzd_pkg::PH_TOKHI;
            end
            lzd_pkg::PH_TOKHI: begin
               cnt_in   = lzd_pkg::sat_add(e_cnt, {1'b0, e_tok[7:4]} + lzd_pkg::LEN_BIAS);
               flags_in = {e_flags[6:0], 1'b0};
               idx_in   = e_idx + 4'd1;
               phase_in = choose_next(cnt_in, e_tgt, idx_in, flags_in);
               pend_in  = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // command output
   always_comb begin
      q_push         = accept && (e_phase == lzd_pkg::PH_LIT || e_phase == lzd_pkg::PH_TOKHI);
      q_cmd.restart  = pend_ff || req_start_req;
      q_cmd.is_lit   = (e_phase == lzd_pkg::PH_LIT);
      q_cmd.lit_byte = req_in_byte;
      q_cmd.disp     = {e_tok[3:0], req_in_byte};
      q_cmd.len      = (e_phase == lzd_pkg::PH_LIT) ? lzd_pkg::LEN_W'(1)
                                                     : {1'b0, e_tok[7:4]} + lzd_pkg::LEN_BIAS;
      q_cmd.base     = e_cnt;
      q_cmd.target   = e_tgt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lzd_pkg::PH_HEADER;
         hdr_ff   <= '0;
         tgt_ff   <= '0;
         cnt_ff   <= '0;
         flags_ff <= '0;
         idx_ff   <= '0;
         tok_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         tgt_ff   <= tgt_in;
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         idx_ff   <= idx_in;
         tok_ff   <= tok_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lzd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lzd_cmd_fifo
// Small command queue between the stream parser and the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_cmd_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lzd_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  pop_valid,
   output lzd_pkg::cmd_type      pop_cmd
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   lzd_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_cmd   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== design/lzd_back.sv =====
// ----------------------------------------------------------------------------
// lzd_back
// Copy engine: runs emit commands against the 4 KB history window, one byte
// per cycle unless stalled (issue/read stage, write stage, output register).
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire lzd_pkg::cmd_type q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last,
   output logic                  rsp_done_res
);

   localparam int unsigned WW = lzd_pkg::WIN_W;
   localparam int unsigned SW = lzd_pkg::SIZE_W;
   localparam int unsigned LW = lzd_pkg::LEN_W;

   logic [7:0] win_mem [2**WW];

   // issue stage
   logic          act_ff, act_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic          lit_ff, lit_in;
   logic [7:0]    byte_ff, byte_in;
   logic [WW-1:0] disp_ff, disp_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] tgt_ff, tgt_in;
   logic [WW-1:0] ip_ff, ip_in;

   // write stage
   logic          w_valid_ff, w_valid_in;
   logic          w_lit_ff, w_zero_ff, w_fwd_ff;
   logic [7:0]    w_byte_ff, w_fwd_data_ff, rd_data_ff;
   logic [WW-1:0] w_addr_ff;
   logic          w_last_ff, w_done_ff;

   // output register
   logic          o_valid_ff, o_valid_in;
   logic [7:0]    o_byte_ff;
   logic          o_last_ff, o_done_ff;

   logic          out_free, w_fire, w_move, issue, load;
   logic [WW-1:0] rd_addr;
   logic [7:0]    w_value;
   logic [SW-1:0] cnt_next;
   logic          i_zero, i_done;

   assign out_free = !o_valid_ff || rsp_ready;
   assign w_fire   = w_valid_ff && out_free;
   assign w_move   = !w_valid_ff || out_free;
   assign issue    = act_ff && w_move;
   assign load     = q_valid && (!act_ff || (issue && rem_ff == LW'(1)));
   assign q_pop    = load;

   assign rd_addr  = ip_ff - disp_ff - WW'(1);
   assign cnt_next = lzd_pkg::sat_add(cnt_ff, LW'(1));
   // bytes reaching before the start of this stream read as zero
   assign i_zero   = ({{(SW-WW-1){1'b0}}, {1'b0, disp_ff} + (WW+1)'(1)} > cnt_ff);
   assign i_done   = (cnt_next >= tgt_ff);

   always_comb begin
      if (w_lit_ff) begin
         w_value = w_byte_ff;
      end else if (w_zero_ff) begin
         w_value = 8'd0;
      end else if (w_fwd_ff) begin
         w_value = w_fwd_data_ff;
      end else begin
         w_value = rd_data_ff;
      end
   end

   always_comb begin
      act_in  = act_ff;
      rem_in  = rem_ff;
      lit_in  = lit_ff;
      byte_in = byte_ff;
      disp_in = disp_ff;
      cnt_in  = cnt_ff;
      tgt_in  = tgt_ff;
      ip_in   = ip_ff;
      if (issue) begin
         rem_in = rem_ff - LW'(1);
         cnt_in = cnt_next;
         ip_in  = ip_ff + WW'(1);
         if (rem_ff == LW'(1)) begin
            act_in = 1'b0;
         end
      end
      if (load) begin
         act_in  = 1'b1;
         rem_in  = q_cmd.len;
         lit_in  = q_cmd.is_lit;
         byte_in = q_cmd.lit_byte;
         disp_in = q_cmd.disp;
         cnt_in  = q_cmd.base;
         tgt_in  = q_cmd.target;
         if (q_cmd.restart) begin
            ip_in = '0;
         end
      end
      w_valid_in = issue ? 1'b1 : (w_fire ? 1'b0 : w_valid_ff);
      o_valid_in = w_fire ? 1'b1 : (rsp_ready ? 1'b0 : o_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff     <= 1'b0;
         ip_ff      <= '0;
         w_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         act_ff     <= act_in;
         ip_ff      <= ip_in;
         w_valid_ff <= w_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      lit_ff  <= lit_in;
      byte_ff <= byte_in;
      disp_ff <= disp_in;
      cnt_ff  <= cnt_in;
      tgt_ff  <= tgt_in;
      if (issue) begin
         w_lit_ff      <= lit_ff;
         w_zero_ff     <= i_zero;
         w_byte_ff     <= byte_ff;
         w_addr_ff     <= ip_ff;
         w_last_ff     <= (rem_ff == LW'(1));
         w_done_ff     <= i_done;
         // the byte being written this cycle may be the one read this cycle
         w_fwd_ff      <= w_fire && (w_addr_ff == rd_addr);
         w_fwd_data_ff <= w_value;
      end
      if (w_fire) begin
         o_byte_ff <= w_value;
         o_last_ff <= w_last_ff;
         o_done_ff <= w_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= win_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (w_fire) begin
         win_mem[w_addr_ff] <= w_value;
      end
   end

   assign rsp_valid    = o_valid_ff;
   assign rsp_out_byte = o_byte_ff;
   assign rsp_last     = o_last_ff;
   assign rsp_done_res = o_done_ff;

endmodule

`default_nettype wire

// ===== design/lz77_byte_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz77_byte_decompressor
// LZ77 (type 10h) stream decompressor, one compressed byte per request.
//
// req_* carries one compressed byte per request; req_start_req marks the first
// header byte of a new stream and abandons any stream in progress. rsp_*
// returns decompressed bytes in order; rsp_last marks the final byte caused by
// a request, rsp_done_res marks bytes at or beyond the header size. Header,
// flag and first token bytes produce no response.
// A request is parsed and queued as an emit command. The copy engine writes
// one byte per cycle to the window while rsp_ready allows; a literal writes
// one byte, a back reference of length L (3..18) writes L bytes, and commands
// follow with no gap. With the engine idle, a request's first byte becomes
// valid once through the queue, issue stage, write stage and output register.
// Requests are taken while the command queue (QUEUE_DEPTH entries) has room.
// Reset clears the parser, queue and pipeline; the window RAM is not cleared,
// references before the stream start read zero instead. A low rsp_ready holds
// the output register and the copy pipeline; the queue then fills and
// req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_byte_decompressor #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_start_req,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last,
   output logic            rsp_done_res
);

   logic             q_full, q_push, q_pop, q_valid;
   lzd_pkg::cmd_type push_cmd, pop_cmd;

   lzd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_start_req (req_start_req),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   lzd_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   lzd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (pop_cmd),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_done_res (rsp_done_res)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command popped from an empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_cmd_len: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (push_cmd.is_lit ? (push_cmd.len == 5'd1)
                                  : (push_cmd.len >= 5'd3 && push_cmd.len <= 5'd18)))
      else $error("emit command with bad length");

endmodule

`default_nettype wire

// ===== tb/tb_lz77_byte_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz77_byte_decompressor
// Drives compressed LZ77 streams one byte per request and checks every
// decompressed byte, its last and done flags against an in-bench decoder.
// Directed streams hit the corner cases, then random well-formed streams
// with some aborted ones run under several idle and stall mixes.
// ----------------------------------------------------------------------------

module tb_lz77_byte_decompressor;

   localparam int CLK_HALF       = 2;
   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int ITEMS_PER_MIX  = 100;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
   } rsp_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_start_req = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       rsp_done_res;

   // decoder state
   lzd_pkg::phase_type         ph;
   logic [1:0]                 hdr_cnt;
   logic [lzd_pkg::SIZE_W-1:0] size_tgt;
   logic [lzd_pkg::SIZE_W-1:0] emitted;
   logic [7:0]                 flags;
   logic [3:0]                 flag_pos;
   logic [7:0]                 tok_first;
   logic [7:0]                 window_mem [0:4095];
   logic [lzd_pkg::WIN_W-1:0]  wr_ptr;

   rsp_beat_type expected_out[$];
   int           fail_count = 0;
   int           items_sent = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           quiet_cycles = 0;

   lz77_byte_decompressor u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .rsp_done_res  (rsp_done_res)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // ---------------------------------------------------------------- decoder
   function automatic void pick_phase();
      if (emitted >= size_tgt)
         ph = lzd_pkg::PH_DONE;
      else if (flag_pos >= lzd_pkg::FLAG_CNT)
         ph = lzd_pkg::PH_FLAG;
      else
         ph = flags[7] ? lzd_pkg::PH_TOKLO : lzd_pkg::PH_LIT;
   endfunction

   function automatic void record_byte(input logic [7:0] v, input logic is_last);
      rsp_beat_type beat;
      window_mem[wr_ptr] = v;
      wr_ptr = wr_ptr + 12'd1;
      if (emitted != lzd_pkg::SIZE_MAX)
         emitted = emitted + 24'd1;
      beat.data = v;
      beat.last = is_last;
      beat.done = (emitted >= size_tgt);
      expected_out.push_back(beat);
   endfunction

   function automatic void next_block();
      flags = flags << 1;
      flag_pos = flag_pos + 4'd1;
      pick_phase();
   endfunction

   function automatic void clear_stream();
      ph = lzd_pkg::PH_HEADER;
      hdr_cnt = 2'd0;
      size_tgt = '0;
      emitted = '0;
      wr_ptr = '0;
      flags = 8'h00;
      flag_pos = 4'd0;
      tok_first = 8'h00;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic st);
      logic [11:0] disp_val;
      int          len;
      logic [7:0]  v;
      if (st)
         clear_stream();
      case (ph)
         lzd_pkg::PH_HEADER: begin
            case (hdr_cnt)
               2'd1: size_tgt[7:0] = b;
               2'd2: size_tgt[15:8] = b;
               2'd3: size_tgt[23:16] = b;
               default: ;
            endcase
            if (hdr_cnt == 2'd3) begin
               hdr_cnt = 2'd0;
               flag_pos = lzd_pkg::FLAG_CNT;
               pick_phase();
            end else begin
               hdr_cnt = hdr_cnt + 2'd1;
            end
         end
         lzd_pkg::PH_FLAG: begin
            flags = b;
            flag_pos = 4'd0;
            pick_phase();
         end
         lzd_pkg::PH_LIT: begin
            record_byte(b, 1'b1);
            next_block();
         end
         lzd_pkg::PH_TOKLO: begin
            tok_first = b;
            ph = lzd_pkg::PH_TOKHI;
         end
         lzd_pkg::PH_TOKHI: begin
            disp_val = {tok_first[3:0], b};
            len = int'(tok_first[7:4]) + int'(lzd_pkg::LEN_BIAS);
            for (int i = 0; i < len; i++) begin
               // distances past the stream start read zero
               v = ({12'd0, disp_val} < emitted) ? window_mem[wr_ptr - disp_val - 12'd1]
                                                 : 8'h00;
               record_byte(v, i == len - 1);
            end
            next_block();
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic send_byte(input logic [7:0] b, input logic st);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_start_req <= st;
      do @(posedge clock); while (!req_ready);
      decode_byte(b, st);
      items_sent++;
   endtask

   task automatic drain(input int idle_pct, input int stall);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_out.size() != 0);
      send_idle_pct = idle_pct;
      stall_pct = stall;
   endtask

   // one stream; random content, aborted now and then
   task automatic play_stream(input logic [23:0] size);
      logic [7:0]  hdr;
      logic [11:0] disp_val;
      logic [7:0]  disp_lo;
      logic [3:0]  len_code;
      int          reach;
      send_byte(8'h10, 1'b1);
      while (ph != lzd_pkg::PH_DONE) begin
         if ($urandom_range(39) == 0) begin
            send_byte(8'($urandom_range(255)), 1'b1);
         end else begin
            case (ph)
               lzd_pkg::PH_HEADER: begin
                  case (hdr_cnt)
                     2'd0: hdr = 8'($urandom_range(255));
                     2'd1: hdr = size[7:0];
                     2'd2: hdr = size[15:8];
                     default: hdr = size[23:16];
                  endcase
                  send_byte(hdr, 1'b0);
               end
               lzd_pkg::PH_FLAG: send_byte(8'($urandom_range(255)), 1'b0);
               lzd_pkg::PH_LIT: send_byte(8'($urandom_range(255)), 1'b0);
               lzd_pkg::PH_TOKLO: begin
                  reach = (emitted > 24'd4096) ? 4095 : int'(emitted) - 1;
                  if (emitted == 0 || $urandom_range(9) == 0)
                     disp_val = 12'($urandom);
                  else if ($urandom_range(2) == 0)
                     disp_val = 12'($urandom_range(reach > 3 ? 3 : reach));
                  else
                     disp_val = 12'($urandom_range(reach));
                  len_code = 4'($urandom_range(15));
                  disp_lo = disp_val[7:0];
                  send_byte({len_code, disp_val[11:8]}, 1'b0);
               end
               default: send_byte(disp_lo, 1'b0);
            endcase
         end
      end
      // ignored until the next start
      repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      // header taken without start right after reset; size 12
      send_byte(8'h10, 1'b0);
      send_byte(8'h0C, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h60, 1'b0);  // literal, then reference
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF0, 1'b0);  // length 18, distance 1: runs past the size
      send_byte(8'h00, 1'b0);
      send_byte(8'hAB, 1'b0);  // after done, ignored
      // maximum size, reference reaching before the stream start
      send_byte(8'h10, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // restart mid-stream into a zero-size stream
      send_byte(8'h10, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h77, 1'b0);
   endtask

   task automatic test_random_streams(input int idle_pct, input int stall);
      logic [23:0] size;
      int          stop_at;
      drain(idle_pct, stall);
      stop_at = items_sent + ITEMS_PER_MIX;
      while (items_sent < stop_at) begin
         case ($urandom_range(15))
            0: size = 24'd0;
            1: size = 24'($urandom_range(400));
            default: size = 24'($urandom_range(40, 1));
         endcase
         play_stream(size);
      end
   endtask

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out.size() == 0) begin
            $error("out_byte: expected none, got %h", rsp_out_byte);
            fail_count++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %h, got %h", want.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               fail_count++;
            end
            if (rsp_done_res !== want.done) begin
               $error("done_res: expected %b, got %b", want.done, rsp_done_res);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("lz77_byte_decompressor: mismatch");
         $finish;
      end
   end

   initial begin
      clear_stream();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_streams(0, 0);
      test_random_streams(45, 0);
      test_random_streams(0, 45);
      test_random_streams(20, 20);
      drain(0, 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("lz77_byte_decompressor: match");
      else
         $display("lz77_byte_decompressor: mismatch");
      $finish;
   end

endmodule

// ===== lz77_byte_decompressor.f =====
design/lzd_pkg.sv
design/lzd_front.sv
design/lzd_cmd_fifo.sv
design/lzd_back.sv
design/lz77_byte_decompressor.sv
tb/tb_lz77_byte_decompressor.sv
